// ----- rtl/glyph_bitmap_expander_macros.svh -----
// Assertion macros for the glyph bitmap expander.
// Used by the controller and the datapath; expects clk and rst_n in scope.
`ifndef GLYPH_BITMAP_EXPANDER_MACROS_SVH
`define GLYPH_BITMAP_EXPANDER_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define GBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define GBE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GBE_ASSERT(lbl, prop, msg)
`define GBE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/gbe_pkg.sv -----
// Shared types, constants and helpers for the glyph bitmap expander.
// No dependencies; imported by gbe_ctrl, gbe_datapath and the top level.
`timescale 1ns / 1ps
package gbe_pkg;

  localparam int GROUP_PIXELS = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_CELLS  = 2'd3
  } cfg_reg_t;

  // encoding modes
  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_RLE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic take;    // capture the input transaction
    logic load;    // set up the run for the captured byte
    logic step;    // add one chunk of up to eight pixels
    logic flush;   // push out the partial group and finish
    logic finish;  // finish without a group
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic settling;    // image size product still updating
    logic finished;    // image done, later bytes are dropped
    logic more;        // pixels left in this byte and in the image
    logic chunk_last;  // current chunk ends the byte's pixels
    logic need_flush;  // partial group waits and the byte ends the image
    logic end_item;    // image size reached or final byte
    logic out_free;    // output register can take a group this cycle
  } dp_status_t;

  // mask of the n lowest bits, n in 0..8
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

endpackage

// ----- rtl/gbe_datapath.sv -----
// Datapath of the glyph bitmap expander: configuration, image size,
// pixel packing and the output register. Depends on gbe_pkg and the macro header.
`timescale 1ns / 1ps
`include "glyph_bitmap_expander_macros.svh"
module gbe_datapath
  import gbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_bits,
  output logic [3:0]  out_valid_pixels,
  output logic [28:0] out_group_index,
  output logic        out_last_of_item,
  output logic        out_image_complete
);

  // configuration and image size
  logic        mode_r;
  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [15:0] cells_r;
  logic [23:0] prod_r;
  logic [31:0] total_r;
  logic [1:0]  settle_r;

  // captured transaction
  logic [7:0] data_r;
  logic       final_r;

  // decoder state
  logic [31:0] pos_r;
  logic [31:0] left_r;
  logic [7:0]  rem_r;
  logic [7:0]  src_r;
  logic        rle_item_r;
  logic        color_r;
  logic [4:0]  rbi_r;
  logic        finished_r;
  logic [7:0]  pend_r;
  logic [2:0]  pend_cnt_r;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_bits_r;
  logic [3:0]  out_count_r;
  logic [28:0] out_index_r;
  logic        out_last_r;
  logic        out_complete_r;

  // helpers
  logic [32:0] left_diff;
  logic [5:0]  row_len;
  logic [8:0]  row_sum;
  logic        in_row;
  logic [7:0]  span;
  logic [7:0]  raw_cnt;
  logic [4:0]  rbi_nxt;
  logic [8:0]  left_sat;
  logic [3:0]  space;
  logic [3:0]  n0;
  logic [3:0]  n;
  logic [7:0]  src_bits;
  logic [7:0]  new_bits;
  logic [7:0]  pend_full;
  logic [3:0]  cnt_full;
  logic        step_complete;
  logic        step_emit;
  logic        more_after;
  logic [31:0] pos_nxt;
  logic [31:0] idx_pos;
  logic [31:0] flush_pos;
  logic        out_free;
  logic        emit_any;

  // image size, two multiplier stages
  always_ff @(posedge clk) begin
    prod_r  <= {8'd0, cells_r} * {16'd0, width_r};
    total_r <= {8'd0, prod_r} * {24'd0, height_r};
  end

  // configuration registers and settle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RLE;
      width_r  <= 8'd8;
      height_r <= 8'd16;
      cells_r  <= 16'd96;
      settle_r <= 2'd2;
    end else begin
      if (cfg_we) begin
        settle_r <= 2'd2;
        unique case (cfg_reg_t'(cfg_index))
          REG_MODE:   mode_r   <= cfg_data[0];
          REG_WIDTH:  width_r  <= cfg_data[7:0];
          REG_HEIGHT: height_r <= cfg_data[7:0];
          REG_CELLS:  cells_r  <= cfg_data;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // byte setup: remaining image size and raw row byte bookkeeping
  always_comb begin
    left_diff = {1'b0, total_r} - {1'b0, pos_r};
    row_sum   = {1'b0, width_r} + 9'd7;
    row_len   = row_sum[8:3];
    in_row    = ({1'b0, rbi_r} < row_len);
    span      = width_r - {rbi_r, 3'b000};
    if (!in_row)
      raw_cnt = 8'd0;
    else if (span > 8'd8)
      raw_cnt = 8'd8;
    else
      raw_cnt = span;
    if (row_len == 6'd0 || ({1'b0, rbi_r} + 6'd1) >= row_len)
      rbi_nxt = 5'd0;
    else
      rbi_nxt = rbi_r + 5'd1;
  end

  // chunk: up to eight pixels, stopping at the byte's end, the group border or image end
  always_comb begin
    left_sat = (left_r[31:9] != 23'd0) ? 9'h1FF : left_r[8:0];
    space    = 4'(GROUP_PIXELS) - {1'b0, pend_cnt_r};
    n0       = (rem_r < {4'd0, space}) ? rem_r[3:0] : space;
    n        = (left_sat < {5'd0, n0}) ? left_sat[3:0] : n0;
    src_bits = src_r;
    new_bits = (src_bits & low_mask(n)) << pend_cnt_r;
    pend_full = pend_r | new_bits;
    cnt_full  = {1'b0, pend_cnt_r} + n;
    step_complete = (left_sat == {5'd0, n});
    step_emit     = step_complete || (cnt_full == 4'(GROUP_PIXELS));
    more_after = ({1'b0, rem_r} > {5'd0, n}) && (left_sat > {5'd0, n}) &&
                 (({1'b0, rem_r} >= ({5'd0, n} + 9'd8)) ||
                  (left_sat <= {1'b0, rem_r}) || final_r);
    pos_nxt   = pos_r + {28'd0, n};
    idx_pos   = pos_r + {28'd0, n - 4'd1};
    flush_pos = pos_r - 32'd1;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit_any = (cmd.step && step_emit) || cmd.flush;

  // captured transaction
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_r  <= in_data_byte;
      final_r <= in_final_byte;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 32'd0;
      left_r     <= 32'd0;
      rem_r      <= 8'd0;
      rle_item_r <= 1'b0;
      color_r    <= 1'b0;
      rbi_r      <= 5'd0;
      finished_r <= 1'b0;
      pend_r     <= 8'd0;
      pend_cnt_r <= 3'd0;
    end else begin
      if (cmd.load && !finished_r) begin
        left_r     <= left_diff[32] ? 32'd0 : left_diff[31:0];
        rle_item_r <= (mode_r == MODE_RLE);
        if (mode_r == MODE_RLE) begin
          rem_r <= data_r;
          if (data_r != 8'hFF)
            color_r <= ~color_r;
        end else begin
          rem_r <= raw_cnt;
          rbi_r <= rbi_nxt;
        end
      end
      if (cmd.step) begin
        pos_r  <= pos_nxt;
        left_r <= left_r - {28'd0, n};
        rem_r  <= rem_r - {4'd0, n};
        if (step_emit) begin
          pend_r     <= 8'd0;
          pend_cnt_r <= 3'd0;
          finished_r <= step_complete;
        end else begin
          pend_r     <= pend_full;
          pend_cnt_r <= cnt_full[2:0];
        end
      end
      if (cmd.flush) begin
        pend_r     <= 8'd0;
        pend_cnt_r <= 3'd0;
        finished_r <= 1'b1;
      end
      if (cmd.finish)
        finished_r <= 1'b1;
    end
  end

  // pixel source: raw byte shifts out as pixels are taken, a run holds the
  // color it had before the byte's toggle
  always_ff @(posedge clk) begin
    if (cmd.load)
      src_r <= (mode_r == MODE_RLE) ? {8{color_r}} : data_r;
    else if (cmd.step && !rle_item_r)
      src_r <= src_r >> n;
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (emit_any)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_bits_r     <= pend_r;
      out_count_r    <= {1'b0, pend_cnt_r};
      out_index_r    <= flush_pos[31:3];
      out_last_r     <= 1'b1;
      out_complete_r <= (left_r == 32'd0);
    end else if (cmd.step && step_emit) begin
      out_bits_r     <= pend_full;
      out_count_r    <= cnt_full;
      out_index_r    <= idx_pos[31:3];
      out_last_r     <= !more_after;
      out_complete_r <= step_complete;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_bits     = out_bits_r;
  assign out_valid_pixels   = out_count_r;
  assign out_group_index    = out_index_r;
  assign out_last_of_item   = out_last_r;
  assign out_image_complete = out_complete_r;

  // status to controller
  always_comb begin
    status.settling   = cfg_we || (settle_r != 2'd0);
    status.finished   = finished_r;
    status.more       = (rem_r != 8'd0) && (left_r != 32'd0);
    status.chunk_last = !(({1'b0, rem_r} > {5'd0, n}) && (left_sat > {5'd0, n}));
    status.end_item   = (left_r == 32'd0) || final_r;
    status.need_flush = (pend_cnt_r != 3'd0) && status.end_item;
    status.out_free   = out_free;
  end

  `GBE_ASSERT(a_emit_slot, (cmd.step || cmd.flush) |-> out_free, "emit into full output")
  `GBE_ASSERT(a_fin_clear, finished_r |-> (pend_cnt_r == 3'd0), "pixels pending after finish")
  `GBE_ASSERT(a_complete_last, (out_valid_r && out_complete_r) |-> out_last_r, "end not last")
  `GBE_ASSERT_NEVER(a_cnt, out_valid_r && (out_count_r - 4'd1) >= 4'(GROUP_PIXELS), "bad count")

endmodule

// ----- rtl/gbe_ctrl.sv -----
// Controller of the glyph bitmap expander: sequences take, setup, chunk
// steps and the end-of-byte flush. Depends on gbe_pkg and the macro header.
`timescale 1ns / 1ps
`include "glyph_bitmap_expander_macros.svh"
module gbe_ctrl
  import gbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FLUSH
  } state_t;

  state_t state_r;

  assign in_stall = (state_r != ST_IDLE) || status.settling;

  // commands
  always_comb begin
    cmd.take   = (state_r == ST_IDLE) && in_valid && !in_stall;
    cmd.load   = (state_r == ST_LOAD);
    cmd.step   = (state_r == ST_RUN) && !status.finished && status.more &&
                 status.out_free;
    cmd.flush  = (state_r == ST_FLUSH) && status.need_flush && status.out_free;
    cmd.finish = (state_r == ST_FLUSH) && !status.need_flush && status.end_item;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.take)
            state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          state_r <= status.finished ? ST_IDLE : ST_RUN;
        end
        ST_RUN: begin
          priority if (status.finished)
            state_r <= ST_IDLE;
          else if (!status.more)
            state_r <= ST_FLUSH;
          else if (cmd.step && status.chunk_last)
            state_r <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (!status.need_flush || status.out_free)
            state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `GBE_ASSERT(a_take_load, cmd.take |=> (state_r == ST_LOAD), "taken byte not set up next cycle")

endmodule

// ----- rtl/glyph_bitmap_expander.sv -----
// Glyph bitmap expander: one byte in, groups of up to eight 1-bit pixels out.
// A byte's first group goes through setup, a chunk step and the output register.
// Input is held off while a byte is set up, split at group borders and flushed;
// output stalls hold its steps. Once the image is finished, bytes are dropped.
// A configuration write holds input off while the size multipliers settle.
// Reset: synchronous, active low; registers return to their reset values.
`timescale 1ns / 1ps
module glyph_bitmap_expander
  import gbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_bits,
  output logic [3:0]  out_valid_pixels,
  output logic [28:0] out_group_index,
  output logic        out_last_of_item,
  output logic        out_image_complete
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gbe_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_bits     (out_pixel_bits),
    .out_valid_pixels   (out_valid_pixels),
    .out_group_index    (out_group_index),
    .out_last_of_item   (out_last_of_item),
    .out_image_complete (out_image_complete)
  );

endmodule

// ----- tb/glyph_bitmap_expander_checker.sv -----
// Checker for the glyph bitmap expander: mirrors the configuration writes,
// predicts the pixel groups of every accepted byte and compares the outputs.
// Depends on gbe_pkg for the register indexes, modes and group size.
`timescale 1ns / 1ps
module glyph_bitmap_expander_checker
  import gbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_pixel_bits,
  input  logic [3:0]  out_valid_pixels,
  input  logic [28:0] out_group_index,
  input  logic        out_last_of_item,
  input  logic        out_image_complete,
  output int          mismatch_count,
  output int          groups_pending
);

  typedef struct packed {
    logic [7:0]  pixels;
    logic [3:0]  count;
    logic [28:0] index;
    logic        last;
    logic        complete;
  } pixel_group_t;

  // configuration mirror
  logic        mode_q;
  logic [7:0]  width_q;
  logic [7:0]  height_q;
  logic [15:0] cells_q;

  // expansion state
  logic [7:0]  pend_bits;
  int unsigned pend_cnt;
  logic [31:0] pixel_pos;
  logic        color;
  logic [4:0]  row_byte;
  logic        done;

  int           fail_total = 0;
  pixel_group_t expected_groups[$];
  pixel_group_t byte_groups[$];

  function automatic void reset_expander();
    mode_q    = MODE_RLE;
    width_q   = 8'd8;
    height_q  = 8'd16;
    cells_q   = 16'd96;
    pend_bits = '0;
    pend_cnt  = 0;
    pixel_pos = '0;
    color     = 1'b0;
    row_byte  = '0;
    done      = 1'b0;
    expected_groups.delete();
  endfunction

  // close the pending group; the position already counts its last pixel
  function automatic void close_group(logic complete);
    pixel_group_t g;
    g.pixels   = pend_bits;
    g.count    = 4'(pend_cnt);
    g.index    = 29'((pixel_pos - 32'd1) / GROUP_PIXELS);
    g.last     = 1'b0;
    g.complete = complete;
    byte_groups.push_back(g);
    pend_bits = '0;
    pend_cnt  = 0;
  endfunction

  function automatic void place_pixel(logic px, longint unsigned image_size);
    if (done || pixel_pos >= image_size) return;
    pend_bits[pend_cnt] = px;
    pend_cnt++;
    pixel_pos++;
    if (pixel_pos == image_size) begin
      close_group(1'b1);
      done = 1'b1;
    end else if (pend_cnt == GROUP_PIXELS) begin
      close_group(1'b0);
    end
  endfunction

  // groups caused by one byte, appended to the expected stream
  function automatic void expand_byte(logic [7:0] data, logic fin);
    longint unsigned image_size;
    int unsigned     row_len;
    int unsigned     first_px;
    int unsigned     px_count;
    image_size = 64'(cells_q) * 64'(width_q) * 64'(height_q);
    byte_groups.delete();
    if (done) return;
    if (mode_q == MODE_RLE) begin
      for (int k = 0; k < data; k++) place_pixel(color, image_size);
      // 255 continues the run in the same color
      if (data != 8'd255) color = ~color;
    end else begin
      row_len  = (width_q + GROUP_PIXELS - 1) / GROUP_PIXELS;
      first_px = row_byte * GROUP_PIXELS;
      px_count = 0;
      // index left past the row by a width change: byte is dropped
      if (row_byte < row_len && first_px < width_q) begin
        px_count = width_q - first_px;
        if (px_count > GROUP_PIXELS) px_count = GROUP_PIXELS;
      end
      for (int k = 0; k < px_count; k++) place_pixel(data[k], image_size);
      if (row_len == 0 || row_byte + 1 >= row_len) row_byte = '0;
      else row_byte = row_byte + 5'd1;
    end
    // image size reached (or shrunk below us) or final byte: flush, finish
    if (!done) begin
      if (pixel_pos >= image_size) begin
        if (pend_cnt != 0) close_group(1'b1);
        done = 1'b1;
      end else if (fin) begin
        if (pend_cnt != 0) close_group(1'b0);
        done = 1'b1;
      end
    end
    if (byte_groups.size() > 0) byte_groups[byte_groups.size() - 1].last = 1'b1;
    foreach (byte_groups[i]) expected_groups.push_back(byte_groups[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_total++;
    end
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    pixel_group_t want;
    if (!rst_n) begin
      reset_expander();
    end else begin
      if (in_valid && !in_stall) expand_byte(in_data_byte, in_final_byte);
      if (out_valid && !out_stall) begin
        if (expected_groups.size() == 0) begin
          $error("unexpected transaction: group_index %0h pixel_bits %0h",
                 out_group_index, out_pixel_bits);
          fail_total++;
        end else begin
          want = expected_groups.pop_front();
          check_field("pixel_bits", 32'(want.pixels), 32'(out_pixel_bits));
          check_field("valid_pixels", 32'(want.count), 32'(out_valid_pixels));
          check_field("group_index", 32'(want.index), 32'(out_group_index));
          check_field("last_of_item", 32'(want.last), 32'(out_last_of_item));
          check_field("image_complete", 32'(want.complete), 32'(out_image_complete));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:   mode_q   = cfg_data[0];
          REG_WIDTH:  width_q  = cfg_data[7:0];
          REG_HEIGHT: height_q = cfg_data[7:0];
          REG_CELLS:  cells_q  = cfg_data;
          default:    ;
        endcase
      end
    end
    groups_pending <= expected_groups.size();
    mismatch_count <= fail_total;
  end

endmodule

// ----- tb/glyph_bitmap_expander_tb.sv -----
// Testbench top for the glyph bitmap expander: clock, reset, register writes,
// byte stimulus and output stall; the checker module does the comparing.
// Depends on gbe_pkg, glyph_bitmap_expander and glyph_bitmap_expander_checker.
`timescale 1ns / 1ps
module glyph_bitmap_expander_tb;
  import gbe_pkg::*;

  localparam int SETTLE_CYCLES  = 8;    // lets a byte with no groups finish, with margin
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 47;
  localparam int TAIL_ITEMS     = 8;
  // longest quiet spell in a good run is a drain plus settle
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    END_FINAL_BYTE,
    END_IMAGE_FULL,
    END_SHRUNK,
    END_ZERO_SIZE
  } ending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_MODE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel_bits;
  logic [3:0]  out_valid_pixels;
  logic [28:0] out_group_index;
  logic        out_last_of_item;
  logic        out_image_complete;

  int          mismatch_count;
  int          groups_pending;
  int          quiet_cycles = 0;
  int unsigned pixels_out_end = 0;
  logic        steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_bitmap_expander u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_bits     (out_pixel_bits),
    .out_valid_pixels   (out_valid_pixels),
    .out_group_index    (out_group_index),
    .out_last_of_item   (out_last_of_item),
    .out_image_complete (out_image_complete)
  );

  glyph_bitmap_expander_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_bits     (out_pixel_bits),
    .out_valid_pixels   (out_valid_pixels),
    .out_group_index    (out_group_index),
    .out_last_of_item   (out_last_of_item),
    .out_image_complete (out_image_complete),
    .mismatch_count     (mismatch_count),
    .groups_pending     (groups_pending)
  );

  // receiver stalls about 12% of cycles, never during a steady phase
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 12);
  end

  // end of the last group seen, rounded up to a whole group, used to size an image just past it
  always @(posedge clk) begin
    if (out_valid && !out_stall) pixels_out_end <= (32'(out_group_index) + 1) * GROUP_PIXELS;
  end

  // watchdog: no transaction and no register write for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction, with random gaps before it
  task automatic send_byte(input logic [7:0] data, input logic fin);
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input logic rle);
    int unsigned sel;
    logic [7:0]  data;
    sel  = $urandom_range(0, 9);
    data = 8'($urandom_range(0, 255));
    // runs: zero, continued, short, or anything
    if (rle) begin
      if (sel == 0) data = 8'd0;
      else if (sel == 1) data = 8'd255;
      else if (sel < 6) data = 8'($urandom_range(1, 16));
    end
    send_byte(data, 1'b0);
  endtask

  // stop sending until every predicted group is out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (groups_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input logic mode, input logic [7:0] width,
                             input logic [7:0] height, input logic [15:0] cells);
    write_reg(REG_MODE, {15'd0, mode});
    write_reg(REG_WIDTH, {8'd0, width});
    write_reg(REG_HEIGHT, {8'd0, height});
    write_reg(REG_CELLS, cells);
    cfg_we <= 1'b0;
  endtask

  initial begin
    ending_t     ending;
    int unsigned pick;
    logic        rle;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: run-length, zero run, full run, both colors
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd254, 1'b0);
    send_byte(8'd7, 1'b0);
    send_byte(8'd8, 1'b0);
    send_byte(8'd9, 1'b0);

    // raw rows, widest cell, single-cell page; leaves the row index at 5
    drain();
    load_config(MODE_RAW, 8'd255, 8'd255, 16'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h01, 1'b0);

    // narrower row: first byte lands past the row, then padding is dropped
    drain();
    load_config(MODE_RAW, 8'd9, 8'd255, 16'hFFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFE, 1'b0);

    // one-pixel rows
    drain();
    load_config(MODE_RAW, 8'd1, 8'd255, 16'hFFFF);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);

    // random phases; image sizes stay far above the pixels sent
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      rle = (phase % 2 == 0);
      case (phase)
        0: load_config(MODE_RLE, 8'd255, 8'd1, 16'hFFFF);
        1: load_config(MODE_RAW, 8'($urandom_range(2, 40)),
                       8'($urandom_range(4, 255)), 16'hFFFF);
        2: load_config(MODE_RLE, 8'd1, 8'd255, 16'hFFFF);
        3: load_config(MODE_RAW, 8'd255, 8'd1, 16'hFFFF);
        4: load_config(MODE_RLE, 8'($urandom_range(16, 255)),
                       8'($urandom_range(16, 255)), 16'($urandom_range(1024, 65535)));
        default: load_config(MODE_RAW, 8'($urandom_range(1, 255)),
                             8'($urandom_range(64, 255)), 16'hFFFF);
      endcase
      steady <= (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(rle);
    end
    steady <= 1'b0;

    // one way of finishing the image per run
    drain();
    ending = ending_t'($urandom_range(0, 3));
    case (ending)
      END_FINAL_BYTE: send_byte(8'($urandom_range(0, 255)), 1'b1);
      END_IMAGE_FULL: begin
        load_config(MODE_RLE, 8'(GROUP_PIXELS), 8'd1,
                    16'(pixels_out_end / GROUP_PIXELS + 2));
        send_byte(8'd255, 1'b0);
      end
      END_SHRUNK: begin
        load_config(MODE_RLE, 8'd1, 8'd1, 16'd1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        pick = $urandom_range(0, 2);
        load_config(MODE_RAW, (pick == 0) ? 8'd0 : 8'd8, (pick == 1) ? 8'd0 : 8'd16,
                    (pick == 2) ? 16'd0 : 16'd96);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase

    // finished: every later byte is dropped
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      send_byte(8'($urandom_range(0, 255)), (n == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gbe_pkg.sv
rtl/gbe_datapath.sv
rtl/gbe_ctrl.sv
rtl/glyph_bitmap_expander.sv
tb/glyph_bitmap_expander_checker.sv
tb/glyph_bitmap_expander_tb.sv
